FILE: rtl/core/text_console_char_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console character writer: assertion macros
// Shared property forms for the checker; all sample on clk and hold off in rst.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Same-cycle implication.
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer package
// Geometry, field widths, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int TERMINALS = 4;
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int DEPTH     = TERMINALS * CELLS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int TIDX_W    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int SCNT_W    = $clog2(COLUMNS);

  localparam int OP_W    = 1;
  localparam int TERM_W  = 2;
  localparam int GLYPH_W = 8;
  localparam int IDX_W   = 11;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int LIN_W   = 11;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = 16;

  localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0720;
  localparam logic [ATTR_W-1:0]  ATTR_RESET   = 8'h07;
  localparam logic [GLYPH_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [GLYPH_W-1:0] RETURN_CODE  = 8'd13;
  localparam logic [OP_W-1:0]    OP_PUT       = 1'b0;
  localparam logic [OP_W-1:0]    OP_READ      = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_SCROLL,
    ST_FORM
  } state_t;

  typedef struct packed {
    logic init_wr;
    logic load;
    logic addr;
    logic do_rd;
    logic do_put;
    logic do_nl;
    logic scroll_clr;
    logic form;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic bad_term;
    logic is_read;
    logic is_nl;
    logic need_scroll;
    logic scroll_last;
  } status_t;

endpackage

FILE: rtl/core/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// Sequences the clear sweep, item decode, cell access, scroll and result beat.
// ----------------------------------------------------------------------------
module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_FORM;
        if (status.bad_term) begin
          state_next = ST_FORM;
        end else if (status.is_read) begin
          cmd.do_rd = 1'b1;
        end else begin
          // newline and glyph both move the cursor; a wrap off the bottom scrolls
          if (status.is_nl) begin
            cmd.do_nl = 1'b1;
          end else begin
            cmd.do_put = 1'b1;
          end
          if (status.need_scroll) begin
            state_next = ST_SCROLL;
          end
        end
      end
      ST_SCROLL: begin
        cmd.scroll_clr = 1'b1;
        if (status.scroll_last) begin
          state_next = ST_FORM;
        end
      end
      ST_FORM: begin
        cmd.form   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/tccw_datapath.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Cell store, per-terminal cursors and ring offsets, address math, results.
// ----------------------------------------------------------------------------
module tccw_datapath
  import tccw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic                cfg_we,
  input  logic [ATTR_W-1:0]   cfg_data,
  input  logic [OP_W-1:0]     op,
  input  logic [TERM_W-1:0]   terminal,
  input  logic [GLYPH_W-1:0]  glyph,
  input  logic [IDX_W-1:0]    cell_index,
  output logic                done,
  output logic [COL_W-1:0]    cursor_col,
  output logic [ROW_W-1:0]    cursor_row,
  output logic [LIN_W-1:0]    cursor_linear,
  output logic                scrolled,
  output logic [GLYPH_W-1:0]  read_glyph,
  output logic [ATTR_W-1:0]   read_attribute
);

  logic [CELL_W-1:0]  mem [DEPTH];
  logic [CELL_W-1:0]  rdata;

  logic [ATTR_W-1:0]  attribute;
  logic [ADDR_W-1:0]  init_cnt;
  logic [SCNT_W-1:0]  scnt;

  logic [COL_W-1:0]   col_pos [TERMINALS];
  logic [ROW_W-1:0]   row_pos [TERMINALS];
  logic [LIN_W-1:0]   top_off [TERMINALS];

  logic [OP_W-1:0]    item_op;
  logic [TERM_W-1:0]  item_term;
  logic [GLYPH_W-1:0] item_glyph;
  logic               item_bad;
  logic               item_idx_ok;
  logic [IDX_W-1:0]   item_idx;
  logic [LIN_W-1:0]   lin;
  logic [ADDR_W-1:0]  base;
  logic               scroll_flag;

  logic [TIDX_W-1:0]  t_idx;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [LIN_W-1:0]   cur_top;
  logic               last_col;
  logic               last_row;
  logic               is_nl;
  logic               need_scroll;
  logic [LIN_W-1:0]   off_sel;
  logic [LIN_W:0]     sum;
  logic [LIN_W:0]     sum_wrap;
  logic [LIN_W:0]     top_sum;
  logic [LIN_W:0]     top_wrap;
  logic [ADDR_W-1:0]  phys_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;

  assign t_idx    = item_term[TIDX_W-1:0];
  assign cur_col  = col_pos[t_idx];
  assign cur_row  = row_pos[t_idx];
  assign cur_top  = top_off[t_idx];
  assign last_col = (cur_col == COL_W'(COLUMNS - 1));
  assign last_row = (cur_row == ROW_W'(ROWS - 1));
  assign is_nl    = (item_glyph == NEWLINE_CODE) || (item_glyph == RETURN_CODE);
  assign need_scroll = last_row && (is_nl || last_col);

  // logical cell offset to physical: rows live in a ring starting at top_off
  assign off_sel   = cmd.scroll_clr ? LIN_W'(scnt) : lin;
  assign sum       = {1'b0, off_sel} + {1'b0, cur_top};
  assign sum_wrap  = (sum >= (LIN_W+1)'(CELLS)) ? sum - (LIN_W+1)'(CELLS) : sum;
  assign phys_addr = base + ADDR_W'(sum_wrap[LIN_W-1:0]);
  assign top_sum   = {1'b0, cur_top} + (LIN_W+1)'(COLUMNS);
  assign top_wrap  = (top_sum >= (LIN_W+1)'(CELLS)) ? top_sum - (LIN_W+1)'(CELLS) : top_sum;

  assign status.init_last   = (init_cnt == ADDR_W'(DEPTH - 1));
  assign status.bad_term    = item_bad;
  assign status.is_read     = (item_op == OP_READ);
  assign status.is_nl       = is_nl;
  assign status.need_scroll = need_scroll;
  assign status.scroll_last = (scnt == SCNT_W'(COLUMNS - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys_addr;
    mem_wdata = {attribute, item_glyph};
    if (cmd.init_wr) begin
      mem_we    = 1'b1;
      mem_waddr = init_cnt;
      mem_wdata = BLANK_CELL;
    end else if (cmd.scroll_clr) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (cmd.do_put) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.do_rd) begin
      rdata <= mem[phys_addr];
    end
  end

  // control state: counters, cursors, ring offsets, attribute, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
      init_cnt  <= '0;
      scnt      <= '0;
      done      <= 1'b0;
      for (int i = 0; i < TERMINALS; i++) begin
        col_pos[i] <= '0;
        row_pos[i] <= '0;
        top_off[i] <= '0;
      end
    end else begin
      done <= cmd.form;
      if (cfg_we) begin
        attribute <= cfg_data;
      end
      if (cmd.init_wr) begin
        init_cnt <= init_cnt + ADDR_W'(1);
      end
      if (cmd.scroll_clr) begin
        if (status.scroll_last) begin
          scnt           <= '0;
          top_off[t_idx] <= top_wrap[LIN_W-1:0];
        end else begin
          scnt <= scnt + SCNT_W'(1);
        end
      end
      if (cmd.do_put) begin
        if (last_col) begin
          col_pos[t_idx] <= '0;
          if (!last_row) begin
            row_pos[t_idx] <= cur_row + ROW_W'(1);
          end
        end else begin
          col_pos[t_idx] <= cur_col + COL_W'(1);
        end
      end
      if (cmd.do_nl) begin
        col_pos[t_idx] <= '0;
        if (!last_row) begin
          row_pos[t_idx] <= cur_row + ROW_W'(1);
        end
      end
    end
  end

  // item capture, address setup and result forming
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op     <= op;
      item_term   <= terminal;
      item_glyph  <= glyph;
      item_idx    <= cell_index;
      item_bad    <= (int'(terminal) >= TERMINALS);
      item_idx_ok <= (int'(cell_index) < CELLS);
      scroll_flag <= 1'b0;
    end
    if (cmd.addr) begin
      base <= ADDR_W'(t_idx) * ADDR_W'(CELLS);
      if (item_op == OP_READ) begin
        lin <= LIN_W'(item_idx);
      end else begin
        lin <= LIN_W'(cur_row) * LIN_W'(COLUMNS) + LIN_W'(cur_col);
      end
    end
    if ((cmd.do_put || cmd.do_nl) && need_scroll) begin
      scroll_flag <= 1'b1;
    end
    if (cmd.form) begin
      if (item_bad) begin
        cursor_col     <= '0;
        cursor_row     <= '0;
        cursor_linear  <= '0;
        scrolled       <= 1'b0;
        read_glyph     <= '0;
        read_attribute <= '0;
      end else begin
        cursor_col    <= cur_col;
        cursor_row    <= cur_row;
        cursor_linear <= LIN_W'(cur_row) * LIN_W'(COLUMNS) + LIN_W'(cur_col);
        scrolled      <= scroll_flag;
        if ((item_op == OP_READ) && item_idx_ok) begin
          read_glyph     <= rdata[GLYPH_W-1:0];
          read_attribute <= rdata[CELL_W-1:GLYPH_W];
        end else begin
          read_glyph     <= '0;
          read_attribute <= '0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer
// Multi-terminal 80x25 text console: put characters with wrap and scroll,
// read back single cells, report the cursor after every command.
// ----------------------------------------------------------------------------
// Raise start with a command on op/terminal/glyph/cell_index; it is taken on
// the edge where start is high and busy is low. Every command returns exactly
// one result beat: done is high for one cycle with the fields valid, and the
// receiver cannot stall it, so capture it on that cycle. Plain characters,
// newlines and reads pass through capture, address setup, cell access and
// result before the next accept; the result beat shows in the first cycle
// with busy low, so it can coincide with the next accept. A command that
// scrolls also runs a row sweep: the screen rows are kept as a ring in one
// cell memory, so a scroll only rotates the ring and clears the new bottom
// row to zero, one cell a cycle, through the memory write port. After reset
// the block clears all 8000 cells to space with attribute 0x07, one per
// cycle, and holds busy high until that sweep is done. The attribute
// register may be written at any time on the cfg channel (always ready),
// but only between commands for defined behavior.
// ----------------------------------------------------------------------------
module text_console_char_writer
  import tccw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [TERM_W-1:0]   terminal,
  input  logic [GLYPH_W-1:0]  glyph,
  input  logic [IDX_W-1:0]    cell_index,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ATTR_W-1:0]   cfg_data,
  output logic                done,
  output logic [COL_W-1:0]    cursor_col,
  output logic [ROW_W-1:0]    cursor_row,
  output logic [LIN_W-1:0]    cursor_linear,
  output logic                scrolled,
  output logic [GLYPH_W-1:0]  read_glyph,
  output logic [ATTR_W-1:0]   read_attribute
);

  cmd_t    cmd;
  status_t status;

  // attribute writes go straight into the attribute register; never hold off the cfg beat
  assign cfg_ready = 1'b1;

  // sequence: clear sweep, then capture -> address -> access/scroll -> result
  tccw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // cell memory, cursors, ring offsets and registered result fields
  tccw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .op             (op),
    .terminal       (terminal),
    .glyph          (glyph),
    .cell_index     (cell_index),
    .done           (done),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .cursor_linear  (cursor_linear),
    .scrolled       (scrolled),
    .read_glyph     (read_glyph),
    .read_attribute (read_attribute)
  );

endmodule

FILE: rtl/core/tccw_checker.sv
// ----------------------------------------------------------------------------
// Text console checker
// Port-level properties of command, busy and result beats; bound to the top.
// ----------------------------------------------------------------------------
`include "text_console_char_writer_defines.svh"

module tccw_checker
  import tccw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [COL_W-1:0]  cursor_col,
  input logic [ROW_W-1:0]  cursor_row,
  input logic [LIN_W-1:0]  cursor_linear,
  input logic              scrolled
);

  `TCCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")

  `TCCW_ASSERT_NOW(a_done_idle, done, !busy, "result beat while still busy")

  `TCCW_ASSERT_NEXT(a_done_single, done, !done, "result beat longer than one cycle")

  `TCCW_ASSERT_NOW(a_linear, done, cursor_linear == LIN_W'(cursor_row) * LIN_W'(COLUMNS) + LIN_W'(cursor_col), "cursor_linear does not match row and column")

  `TCCW_ASSERT_NOW(a_scroll_pos, done && scrolled, (cursor_col == '0) && (cursor_row == ROW_W'(ROWS - 1)), "scroll left cursor off bottom row start")

endmodule

bind text_console_char_writer tccw_checker u_checker (.*);
